[sv/fbp_pkg.sv]
// Shared types and constants for the flash byte program sequencer.
// Holds the request/response payload structs, phase and job encodings.
// No dependencies.
package fbp_pkg;

   // Width of the address fields on both channels
   localparam int FIELD_ADDR_BITS = 20;

   // Depth of the queue between the front and back ends
   localparam int QUEUE_DEPTH = 2;

   // Number of responses a program request produces
   localparam int PROGRAM_RESULTS = 5;

   // Request commands
   localparam logic CMD_PROGRAM   = 1'b0;
   localparam logic CMD_READ_DATA = 1'b1;

   // Response actions
   localparam logic [1:0] ACT_WRITE  = 2'd0;
   localparam logic [1:0] ACT_READ   = 2'd1;
   localparam logic [1:0] ACT_DONE   = 2'd2;
   localparam logic [1:0] ACT_REJECT = 2'd3;

   // Unlock and command-setup bus cycles
   localparam logic [FIELD_ADDR_BITS-1:0] UNLOCK_ADDR_A = 20'h05555;
   localparam logic [FIELD_ADDR_BITS-1:0] UNLOCK_ADDR_B = 20'h02AAA;
   localparam logic [7:0] UNLOCK_DATA_A      = 8'hAA;
   localparam logic [7:0] UNLOCK_DATA_B      = 8'h55;
   localparam logic [7:0] PROGRAM_SETUP_DATA = 8'hA0;

   typedef struct packed {
      logic                       command;
      logic [FIELD_ADDR_BITS-1:0] flash_address;
      logic [7:0]                 data_byte;
   } req_type;

   typedef struct packed {
      logic [1:0]                 action;
      logic [FIELD_ADDR_BITS-1:0] bus_address;
      logic [7:0]                 bus_data;
      logic                       last;
   } rsp_type;

   typedef enum logic [2:0] {
      PH_IDLE           = 3'd0,
      PH_POLL_FIRST     = 3'd1,
      PH_POLL_SECOND    = 3'd2,
      PH_CONFIRM_FIRST  = 3'd3,
      PH_CONFIRM_SECOND = 3'd4
   } phase_type;

   typedef enum logic [1:0] {
      JOB_PROGRAM = 2'd0,
      JOB_READ    = 2'd1,
      JOB_DONE    = 2'd2,
      JOB_REJECT  = 2'd3
   } job_kind_type;

   typedef struct packed {
      job_kind_type               kind;
      logic [FIELD_ADDR_BITS-1:0] address;
      logic [7:0]                 data;
   } job_type;

endpackage

[sv/fbp_front.sv]
// Front end: accepts requests, tracks the toggle-poll phase and classifies
// each request into a job for the back end.
// Depends on fbp_pkg.
module fbp_front #(
   parameter int ADDR_WIDTH = 20
) (
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   output logic            req_ready,
   input  fbp_pkg::req_type req_payload,
   output logic            job_valid,
   input  logic            job_ready,
   output fbp_pkg::job_type job
);
   import fbp_pkg::*;

   // Keep the low ADDR_WIDTH bits, capped at the field width
   localparam int KEEP_BITS = (ADDR_WIDTH < FIELD_ADDR_BITS) ? ADDR_WIDTH : FIELD_ADDR_BITS;
   localparam logic [FIELD_ADDR_BITS-1:0] ADDR_MASK =
      FIELD_ADDR_BITS'((64'd1 << KEEP_BITS) - 64'd1);

   phase_type                  phase_ff, phase_in;
   logic [FIELD_ADDR_BITS-1:0] target_ff, target_in;
   logic [7:0]                 first_ff, first_in;
   logic                       accept;
   logic                       idle;
   logic                       match;

   assign req_ready = job_ready;
   assign job_valid = req_valid;
   assign accept    = req_valid && req_ready;
   assign match     = (first_ff == req_payload.data_byte);

   // Hold phase and poll state
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= PH_IDLE;
         target_ff <= '0;
         first_ff  <= '0;
      end else begin
         phase_ff  <= phase_in;
         target_ff <= target_in;
         first_ff  <= first_in;
      end
   end

   // Classify the request and advance the phase on accept
   always_comb begin
      phase_in    = phase_ff;
      target_in   = target_ff;
      first_in    = first_ff;
      job.kind    = JOB_REJECT;
      job.address = '0;
      job.data    = '0;
      idle        = 1'b0;

      unique case (phase_ff) inside
         PH_POLL_FIRST, PH_POLL_SECOND, PH_CONFIRM_FIRST, PH_CONFIRM_SECOND: idle = 1'b0;
         default: idle = 1'b1;
      endcase

      if (req_payload.command == CMD_PROGRAM) begin
         if (idle) begin
            job.kind    = JOB_PROGRAM;
            job.address = req_payload.flash_address & ADDR_MASK;
            job.data    = req_payload.data_byte;
            if (accept) begin
               target_in = req_payload.flash_address & ADDR_MASK;
               phase_in  = PH_POLL_FIRST;
            end
         end
      end else if (!idle) begin
         job.kind    = JOB_READ;
         job.address = target_ff;
         unique case (phase_ff)
            PH_POLL_FIRST: begin
               if (accept) begin
                  first_in = req_payload.data_byte;
                  phase_in = PH_POLL_SECOND;
               end
            end
            PH_POLL_SECOND: begin
               if (accept) phase_in = match ? PH_CONFIRM_FIRST : PH_POLL_FIRST;
            end
            PH_CONFIRM_FIRST: begin
               if (accept) begin
                  first_in = req_payload.data_byte;
                  phase_in = PH_CONFIRM_SECOND;
               end
            end
            default: begin
               if (match) job.kind = JOB_DONE;
               if (accept) phase_in = match ? PH_IDLE : PH_POLL_FIRST;
            end
         endcase
      end
   end

   // A program accepted while idle always enters polling
   a_program_starts_poll: assert property (@(posedge clock) disable iff (reset)
      accept && req_payload.command == CMD_PROGRAM && idle |=> phase_ff == PH_POLL_FIRST)
      else $error("program request did not start polling");

   // A rejected request leaves the phase untouched
   a_reject_holds_phase: assert property (@(posedge clock) disable iff (reset)
      accept && job.kind == JOB_REJECT |=> phase_ff == $past(phase_ff))
      else $error("rejected request changed the phase");

endmodule

[sv/fbp_queue.sv]
// Short job queue that decouples the front end from the back end.
// Depends on fbp_pkg.
module fbp_queue (
   input  logic            clock,
   input  logic            reset,
   input  logic            in_valid,
   output logic            in_ready,
   input  fbp_pkg::job_type in_job,
   output logic            out_valid,
   input  logic            out_ready,
   output fbp_pkg::job_type out_job
);
   import fbp_pkg::*;

   localparam int PTR_BITS   = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int COUNT_BITS = $clog2(QUEUE_DEPTH + 1);
   localparam logic [COUNT_BITS-1:0] FULL_COUNT = COUNT_BITS'(QUEUE_DEPTH);
   localparam logic [PTR_BITS-1:0]   LAST_PTR   = PTR_BITS'(QUEUE_DEPTH - 1);

   job_type                entry_ff [QUEUE_DEPTH];
   logic [PTR_BITS-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [PTR_BITS-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [COUNT_BITS-1:0]  count_ff, count_in;
   logic                   push, pop;

   assign in_ready  = (count_ff != FULL_COUNT);
   assign out_valid = (count_ff != '0);
   assign out_job   = entry_ff[rd_ptr_ff];
   assign push      = in_valid && in_ready;
   assign pop       = out_valid && out_ready;

   // Advance pointers and count
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + 1'b1;
      if (pop)  rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + 1'b1;
      if (push && !pop)      count_in = count_ff + 1'b1;
      else if (pop && !push) count_in = count_ff - 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Store the pushed job
   always_ff @(posedge clock) begin
      if (push) entry_ff[wr_ptr_ff] <= in_job;
   end

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= FULL_COUNT)
      else $error("queue count beyond depth");

   a_push_only_grows: assert property (@(posedge clock) disable iff (reset)
      push && !pop |=> count_ff == $past(count_ff) + 1'b1)
      else $error("queue count did not grow on push");

   a_pointers_track_count: assert property (@(posedge clock) disable iff (reset)
      count_ff == '0 |-> wr_ptr_ff == rd_ptr_ff)
      else $error("empty queue with split pointers");

endmodule

[sv/fbp_back.sv]
// Back end: expands each job into bus access responses, one per cycle
// while rsp_ready holds, through a registered response stage.
// Depends on fbp_pkg.
module fbp_back (
   input  logic            clock,
   input  logic            reset,
   input  logic            job_valid,
   output logic            job_ready,
   input  fbp_pkg::job_type job,
   output logic            rsp_valid,
   input  logic            rsp_ready,
   output fbp_pkg::rsp_type rsp_payload
);
   import fbp_pkg::*;

   localparam int STEP_BITS = $clog2(PROGRAM_RESULTS);
   localparam logic [STEP_BITS-1:0] STEP_UNLOCK_A = STEP_BITS'(0);
   localparam logic [STEP_BITS-1:0] STEP_UNLOCK_B = STEP_BITS'(1);
   localparam logic [STEP_BITS-1:0] STEP_SETUP    = STEP_BITS'(2);
   localparam logic [STEP_BITS-1:0] STEP_DATA     = STEP_BITS'(3);
   localparam logic [STEP_BITS-1:0] STEP_LAST     = STEP_BITS'(PROGRAM_RESULTS - 1);

   logic [STEP_BITS-1:0] step_ff, step_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   rsp_type              rsp_ff, rsp_in;
   logic                 load;

   assign load      = job_valid && (!rsp_valid_ff || rsp_ready);
   assign job_ready = load && ((job.kind != JOB_PROGRAM) || (step_ff == STEP_LAST));
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   // Build the response for the current job and step
   always_comb begin
      rsp_in.action      = ACT_REJECT;
      rsp_in.bus_address = '0;
      rsp_in.bus_data    = '0;
      rsp_in.last        = 1'b1;
      unique case (job.kind)
         JOB_PROGRAM: begin
            rsp_in.action = ACT_WRITE;
            rsp_in.last   = 1'b0;
            case (step_ff)
               STEP_UNLOCK_A: begin
                  rsp_in.bus_address = UNLOCK_ADDR_A;
                  rsp_in.bus_data    = UNLOCK_DATA_A;
               end
               STEP_UNLOCK_B: begin
                  rsp_in.bus_address = UNLOCK_ADDR_B;
                  rsp_in.bus_data    = UNLOCK_DATA_B;
               end
               STEP_SETUP: begin
                  rsp_in.bus_address = UNLOCK_ADDR_A;
                  rsp_in.bus_data    = PROGRAM_SETUP_DATA;
               end
               STEP_DATA: begin
                  rsp_in.bus_address = job.address;
                  rsp_in.bus_data    = job.data;
               end
               default: begin
                  rsp_in.action      = ACT_READ;
                  rsp_in.bus_address = job.address;
                  rsp_in.last        = 1'b1;
               end
            endcase
         end
         JOB_READ: begin
            rsp_in.action      = ACT_READ;
            rsp_in.bus_address = job.address;
         end
         JOB_DONE: begin
            rsp_in.action      = ACT_DONE;
            rsp_in.bus_address = job.address;
         end
         default: begin
            rsp_in.action = ACT_REJECT;
         end
      endcase
   end

   // Advance the step and the response valid
   always_comb begin
      step_in      = step_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      if (load) begin
         rsp_valid_in = 1'b1;
         step_in      = job_ready ? '0 : step_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         step_ff      <= step_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Hold the response payload until taken
   always_ff @(posedge clock) begin
      if (load) rsp_ff <= rsp_in;
   end

   a_step_only_in_program: assert property (@(posedge clock) disable iff (reset)
      step_ff != '0 |-> job_valid && job.kind == JOB_PROGRAM)
      else $error("step counter active outside a program job");

   a_write_never_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_ff.action == ACT_WRITE |-> !rsp_ff.last)
      else $error("bus write marked as last response");

   a_single_rsp_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && (rsp_ff.action == ACT_DONE || rsp_ff.action == ACT_REJECT)
      |-> rsp_ff.last)
      else $error("done or reject response not marked last");

endmodule

[sv/flash_byte_program_sequencer_top.sv]
// A program request yields five responses (two unlock writes, the setup
// write, the data write and the first poll read) and a read-data request
// yields one (the next poll read, program done, or a reject). The front end
// classifies and accepts a request every cycle while its two-entry job
// queue has room; the back end emits one response per cycle through a
// registered output stage while rsp_ready holds. Response throughput of
// the back end sets the rate.
// Depends on fbp_pkg, fbp_front, fbp_queue and fbp_back.
module flash_byte_program_sequencer_top #(
   parameter int ADDR_WIDTH = 20
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  fbp_pkg::req_type req_payload,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output fbp_pkg::rsp_type rsp_payload
);
   import fbp_pkg::*;

   logic    fq_valid, fq_ready;
   job_type fq_job;
   logic    qb_valid, qb_ready;
   job_type qb_job;

   // Classify requests
   fbp_front #(.ADDR_WIDTH(ADDR_WIDTH)) u_front (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .job_valid   (fq_valid),
      .job_ready   (fq_ready),
      .job         (fq_job)
   );

   // Buffer jobs between the two sides
   fbp_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (fq_valid),
      .in_ready  (fq_ready),
      .in_job    (fq_job),
      .out_valid (qb_valid),
      .out_ready (qb_ready),
      .out_job   (qb_job)
   );

   // Expand jobs into bus responses
   fbp_back u_back (
      .clock       (clock),
      .reset       (reset),
      .job_valid   (qb_valid),
      .job_ready   (qb_ready),
      .job         (qb_job),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload)
   );

endmodule
